[rtl/tfds_pkg.sv]
package tfds_pkg;

	// default raster size
	localparam int WIDTH_DEF  = 512;
	localparam int HEIGHT_DEF = 512;

	// register map
	localparam logic REG_CLEAR_DEPTH = 1'b0;

	// depth after reset, 1.0 with 16 fraction bits
	localparam logic signed [23:0] CLEAR_RESET = 24'sd65536;

	// corner colour derivation
	localparam logic [31:0] COL_B_ADD = 32'd123123;
	localparam logic [31:0] COL_B_MUL = 32'd123124;
	localparam logic [31:0] COL_C_MUL = 32'd13124;
	localparam logic [31:0] RB_MASK   = 32'h00ff00ff;
	localparam logic [31:0] G_MASK    = 32'h0000ff00;

	// divider geometry
	localparam int DIV_NW = 60;   // dividend bits
	localparam int DIV_DW = 36;   // divisor bits
	localparam int DIV_QW = 24;   // quotient bits
	localparam logic [4:0] DEPTH_STEPS  = 5'd24;
	localparam logic [4:0] FACTOR_STEPS = 5'd9;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_POS,
		ST_EDGE,
		ST_MUL,
		ST_SIGN,
		ST_W0,
		ST_COLB,
		ST_COLC,
		ST_NUM,
		ST_DGO,
		ST_DWAIT,
		ST_FGO,
		ST_FWAIT,
		ST_SHADE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       start;
		logic [4:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_rsp_t;

	// scale one colour word by f/256 per channel
	function automatic logic [31:0] scale_color(input logic [31:0] col, input logic [8:0] f);
		logic [31:0] rb;
		logic [31:0] g;
		begin
			rb = (((col & RB_MASK) * 32'(f)) >> 8) & RB_MASK;
			g  = (((col & G_MASK) * 32'(f)) >> 8) & G_MASK;
			return rb | g;
		end
	endfunction

	// per channel add with saturation, alpha dropped
	function automatic logic [23:0] add_sat(input logic [23:0] p, input logic [31:0] q);
		logic [8:0] b;
		logic [8:0] gg;
		logic [8:0] r;
		begin
			b  = 9'(p[7:0]) + 9'(q[7:0]);
			gg = 9'(p[15:8]) + 9'(q[15:8]);
			r  = 9'(p[23:16]) + 9'(q[23:16]);
			if (b[8]) b = 9'h0ff;
			if (gg[8]) gg = 9'h0ff;
			if (r[8]) r = 9'h0ff;
			return {r[7:0], gg[7:0], b[7:0]};
		end
	endfunction

endpackage

[rtl/tfds_frag_if.sv]
interface tfds_frag_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] ax;
	logic signed [15:0] ay;
	logic signed [23:0] az;
	logic signed [15:0] bx;
	logic signed [15:0] by_coord;
	logic signed [23:0] bz;
	logic signed [15:0] cx;
	logic signed [15:0] cy;
	logic signed [23:0] cz;
	logic        [31:0] base_color;
	logic        [17:0] pixel_index;

	modport source (output valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
		base_color, pixel_index, input ready);
	modport sink (input valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
		base_color, pixel_index, output ready);
endinterface

[rtl/tfds_pix_if.sv]
interface tfds_pix_if;
	logic        valid;
	logic        ready;
	logic [17:0] write_index;
	logic [23:0] write_color;

	modport source (output valid, write_index, write_color, input ready);
	modport sink (input valid, write_index, write_color, output ready);
endinterface

[rtl/tfds_div.sv]
module tfds_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tfds_pkg::div_req_t            req,
	input  logic [tfds_pkg::DIV_NW-1:0]   dividend,
	input  logic [tfds_pkg::DIV_DW-1:0]   divisor,
	output tfds_pkg::div_rsp_t            rsp,
	output logic [tfds_pkg::DIV_QW-1:0]   quotient
);
	import tfds_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_NW-1:0] rem_q;
	logic [DIV_NW-1:0] dsh_q;
	logic [DIV_QW-1:0] quo_q;
	logic              fits;

	assign fits = rem_q >= dsh_q;

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dividend;
			dsh_q <= DIV_NW'(divisor) << (req.steps - 5'd1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[DIV_QW-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.rem_nz = rem_q != '0;
	assign quotient   = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");
	a_steps_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.steps != 5'd0 && req.steps <= 5'(DIV_QW))
		else $error("divider step count out of range");
endmodule

[rtl/triangle_fragment_depth_shade.sv]
// Timing: a fragment that passes is paced by the shared shift-subtract divider
// (24 steps for depth, 3 x 9 for the colour factors) and the single-multiplier
// edge-product sequencer; a clear item or an off-screen pixel returns to idle after the pixel check.
// Throughput: one item at a time; a waiting result
// does not block the next accept.
// Reset: asynchronous, active low; then a clearing sweep over all WIDTH*HEIGHT entries that
// fills the depth memory with 1.0, during which no item is accepted.
module triangle_fragment_depth_shade #(
	parameter int WIDTH  = tfds_pkg::WIDTH_DEF,
	parameter int HEIGHT = tfds_pkg::HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tfds_frag_if.sink   frag,
	tfds_pix_if.source  pix,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tfds_pkg::*;

	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PXW   = $clog2(WIDTH);
	localparam int RSH   = 30;
	localparam logic [44:0] RECIP = 45'((64'd1 << RSH) / WIDTH);

	state_t state_q, state_d;
	logic [2:0]  k_q;
	logic [AW-1:0] clr_q;

	logic signed [23:0] clear_depth_q;

	// item registers
	logic               func_q;
	logic [17:0]        idx_q;
	logic signed [15:0] x_q [3];
	logic signed [15:0] y_q [3];
	logic signed [23:0] z_q [3];
	logic [31:0]        base_q;

	// working registers
	logic [14:0]        qa_q;
	logic [PXW-1:0]     px_q;
	logic [14:0]        py_q;
	logic signed [20:0] ex_q [3];
	logic signed [20:0] ey_q [3];
	logic signed [41:0] u_q [3];
	logic               rej_q;
	logic [35:0]        w_q [3];
	logic [35:0]        uz_q;
	logic signed [63:0] num_q;
	logic signed [23:0] depth_q;
	logic [8:0]         fac_q [3];
	logic [31:0]        col_q [3];
	logic [23:0]        color_q;

	// depth memory
	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [23:0] mem_wdata;

	// output register
	logic        out_valid_q;
	logic [17:0] out_index_q;
	logic [23:0] out_color_q;
	logic        emit_fire;

	// divider
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic [DIV_NW-1:0]   div_dividend;
	logic [DIV_QW-1:0]   div_quo;

	// combinational helpers
	logic               in_range;
	logic [44:0]        pix_prod;
	logic [18:0]        pix_rem;
	logic signed [20:0] op_a, op_b;
	logic signed [41:0] mul_prod;
	logic               uz_neg, degen;
	logic signed [41:0] ux_a, uy_a, uz_a;
	logic signed [42:0] w0_s;
	logic               w0_rej;
	logic [17:0]        half_w;
	logic signed [42:0] num_prod;
	logic signed [63:0] num_term;
	logic [63:0]        num_mag;
	logic [24:0]        dmag;
	logic signed [23:0] depth_calc;
	logic               depth_fail;
	logic               cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CLEAR_DEPTH);
	assign prdata = (paddr[2] == REG_CLEAR_DEPTH) ? {{8{clear_depth_q[23]}}, clear_depth_q}
		: 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clear_depth_q <= CLEAR_RESET;
		else if (cfg_wr) clear_depth_q <= pwdata[23:0];
	end

	// pixel position via reciprocal, one correction step
	assign in_range = 32'(idx_q) < 32'(DEPTH);
	assign pix_prod = 45'(idx_q) * RECIP;
	assign pix_rem  = 19'(idx_q) - 19'(qa_q) * 19'(WIDTH);

	// edge product operand selection
	always_comb begin
		case (k_q)
			3'd0: begin op_a = ex_q[1]; op_b = ey_q[2]; end
			3'd1: begin op_a = ex_q[2]; op_b = ey_q[1]; end
			3'd2: begin op_a = ex_q[2]; op_b = ey_q[0]; end
			3'd3: begin op_a = ex_q[0]; op_b = ey_q[2]; end
			3'd4: begin op_a = ex_q[0]; op_b = ey_q[1]; end
			3'd5: begin op_a = ex_q[1]; op_b = ey_q[0]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end
	assign mul_prod = op_a * op_b;

	// orientation and inside test
	assign uz_neg = u_q[2][41];
	assign degen  = (u_q[2] > -42'sd256) && (u_q[2] < 42'sd256);
	assign ux_a   = uz_neg ? -u_q[0] : u_q[0];
	assign uy_a   = uz_neg ? -u_q[1] : u_q[1];
	assign uz_a   = uz_neg ? -u_q[2] : u_q[2];
	assign w0_s   = 43'(u_q[2]) - 43'(u_q[0]) - 43'(u_q[1]);
	assign w0_rej = rej_q || w0_s[42];

	// depth numerator partial products
	assign half_w   = k_q[0] ? w_q[k_q[2:1]][35:18] : w_q[k_q[2:1]][17:0];
	assign num_prod = z_q[k_q[2:1]] * $signed({1'b0, half_w});
	assign num_term = k_q[0] ? (64'(num_prod) <<< 18) : 64'(num_prod);
	assign num_mag  = num_q[63] ? 64'(-num_q) : 64'(num_q);

	// floor of signed quotient
	assign dmag       = {1'b0, div_quo} + 25'(div_rsp.rem_nz);
	assign depth_calc = num_q[63] ? 24'(-dmag) : div_quo;
	assign depth_fail = $signed(rdata_q) < depth_calc;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (frag.valid) state_d = ST_PIX;
			ST_PIX:   state_d = (!in_range || func_q) ? ST_IDLE : ST_POS;
			ST_POS:   state_d = ST_EDGE;
			ST_EDGE:  state_d = ST_MUL;
			ST_MUL:   if (k_q == 3'd5) state_d = ST_SIGN;
			ST_SIGN:  state_d = ST_W0;
			ST_W0:    state_d = w0_rej ? ST_IDLE : ST_COLB;
			ST_COLB:  state_d = ST_COLC;
			ST_COLC:  state_d = ST_NUM;
			ST_NUM:   if (k_q == 3'd5) state_d = ST_DGO;
			ST_DGO:   state_d = ST_DWAIT;
			ST_DWAIT: if (div_rsp.done) state_d = depth_fail ? ST_IDLE : ST_FGO;
			ST_FGO:   state_d = ST_FWAIT;
			ST_FWAIT: if (div_rsp.done) state_d = (k_q == 3'd2) ? ST_SHADE : ST_FGO;
			ST_SHADE: if (k_q == 3'd2) state_d = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || pix.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		frag.ready    = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = AW'(idx_q);
		mem_wdata     = depth_q;
		div_req.start = 1'b0;
		div_req.steps = FACTOR_STEPS;
		div_dividend  = DIV_NW'({w_q[k_q[1:0]], 8'd0});
		emit_fire     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = CLEAR_RESET;
			end
			ST_IDLE: frag.ready = 1'b1;
			ST_PIX: begin
				mem_we    = in_range && func_q;
				mem_wdata = clear_depth_q;
			end
			ST_POS: mem_re = 1'b1;
			ST_DGO: begin
				div_req.start = 1'b1;
				div_req.steps = DEPTH_STEPS;
				div_dividend  = num_mag[DIV_NW-1:0];
			end
			ST_FGO: div_req.start = 1'b1;
			ST_EMIT: begin
				emit_fire = !out_valid_q || pix.ready;
				mem_we    = emit_fire;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			case (state_q)
				ST_MUL, ST_NUM: k_q <= (k_q == 3'd5) ? 3'd0 : k_q + 3'd1;
				ST_SHADE:       k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
				ST_FWAIT:       if (div_rsp.done) k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
				ST_FGO:         k_q <= k_q;
				default:        k_q <= '0;
			endcase
			if (emit_fire) out_valid_q <= 1'b1;
			else if (pix.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (frag.valid) begin
				func_q <= frag.func;
				idx_q  <= frag.pixel_index;
				x_q[0] <= frag.ax; y_q[0] <= frag.ay;       z_q[0] <= frag.az;
				x_q[1] <= frag.bx; y_q[1] <= frag.by_coord; z_q[1] <= frag.bz;
				x_q[2] <= frag.cx; y_q[2] <= frag.cy;       z_q[2] <= frag.cz;
				base_q <= frag.base_color;
			end
			ST_PIX: qa_q <= pix_prod[RSH+14:RSH];
			ST_POS: begin
				if (pix_rem >= 19'(WIDTH)) begin
					px_q <= PXW'(pix_rem - 19'(WIDTH));
					py_q <= qa_q + 15'd1;
				end else begin
					px_q <= PXW'(pix_rem);
					py_q <= qa_q;
				end
			end
			ST_EDGE: begin
				ex_q[0] <= 21'(x_q[2]) - 21'(x_q[0]);
				ex_q[1] <= 21'(x_q[1]) - 21'(x_q[0]);
				ex_q[2] <= 21'(x_q[0]) - $signed({6'd0, px_q, 4'd0});
				ey_q[0] <= 21'(y_q[2]) - 21'(y_q[0]);
				ey_q[1] <= 21'(y_q[1]) - 21'(y_q[0]);
				ey_q[2] <= 21'(y_q[0]) - $signed({2'd0, py_q, 4'd0});
			end
			ST_MUL: begin
				if (k_q[0]) u_q[k_q[2:1]] <= u_q[k_q[2:1]] - mul_prod;
				else u_q[k_q[2:1]] <= mul_prod;
			end
			ST_SIGN: begin
				u_q[0] <= ux_a;
				u_q[1] <= uy_a;
				u_q[2] <= uz_a;
				rej_q  <= degen || ux_a[41] || uy_a[41];
			end
			ST_W0: begin
				w_q[0] <= w0_s[35:0];
				w_q[1] <= u_q[1][35:0];
				w_q[2] <= u_q[0][35:0];
				uz_q   <= u_q[2][35:0];
				col_q[0] <= base_q;
			end
			ST_COLB: col_q[1] <= (base_q + COL_B_ADD) * COL_B_MUL;
			ST_COLC: col_q[2] <= base_q * COL_C_MUL;
			ST_NUM:  num_q <= ((k_q == 3'd0) ? 64'sd0 : num_q) + num_term;
			ST_DWAIT: if (div_rsp.done) depth_q <= depth_calc;
			ST_FWAIT: if (div_rsp.done) fac_q[k_q[1:0]] <= div_quo[8:0];
			ST_SHADE: color_q <= add_sat((k_q == 3'd0) ? 24'd0 : color_q,
				scale_color(col_q[k_q[1:0]], fac_q[k_q[1:0]]));
			default: ;
		endcase
		if (emit_fire) begin
			out_index_q <= idx_q;
			out_color_q <= color_q;
		end
	end

	// depth memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	tfds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (uz_q),
		.rsp      (div_rsp),
		.quotient (div_quo)
	);

	assign pix.valid       = out_valid_q;
	assign pix.write_index = out_index_q;
	assign pix.write_color = out_color_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");
	a_depth_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !($signed(rdata_q) < depth_q))
		else $error("emit after failed depth test");
	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DWAIT || state_q == ST_FWAIT))
		else $error("divider result not awaited");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !(frag.valid && frag.ready) || $past(clr_q == AW'(DEPTH - 1)))
		else $error("item accepted during clearing sweep");
endmodule
